// File: src/scdd_pkg.sv
// Shared types, constants and the CRC helper for the datagram deframer.
package scdd_pkg;

  localparam int HdrStoreDepth = 16;
  localparam int ShortHdrLen   = 12;
  localparam int LongHdrLen    = 16;

  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [0:0] KIND_DATA   = 1'b0;
  localparam logic [0:0] KIND_NOTICE = 1'b1;

  localparam logic [2:0] CFG_ADDR_SYNC = 3'd0;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_q_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CrcPoly) : (v >> 1);
    end
    return v;
  endfunction

endpackage

// File: src/scdd_front.sv
// Front end: input byte queue and the configuration register port.
module scdd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output scdd_pkg::byte_q_t q_out,
  input  logic             q_pop,
  output logic [15:0]      sync_word
);

  logic [7:0]  mem_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] sync_r, sync_nxt;
  logic        push, pop;

  assign in_tready   = (cnt_r != 2'd2);
  assign push        = in_tvalid && in_tready;
  assign q_out.valid = (cnt_r != 2'd0);
  assign q_out.data  = mem_r[rp_r];
  assign pop         = q_pop && q_out.valid;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    sync_nxt = sync_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
        cfg_paddr == scdd_pkg::CFG_ADDR_SYNC) begin
      sync_nxt = cfg_pwdata[15:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == scdd_pkg::CFG_ADDR_SYNC) ? {16'h0000, sync_r} : 32'h0;
  assign sync_word  = sync_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      cnt_r  <= 2'd0;
      sync_r <= 16'h0000;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      cnt_r  <= cnt_nxt;
      sync_r <= sync_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_tdata;
    end
  end

endmodule

// File: src/scdd_back.sv
// Back end: sync hunt, header CRC check and datagram emission.
module scdd_back #(
  parameter int HEADER_STORE_DEPTH = scdd_pkg::HdrStoreDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  scdd_pkg::byte_q_t q_in,
  output logic             q_pop,
  input  logic [15:0]      sync_word,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast,
  output logic [2:0]       out_tuser
);

  localparam int HW = $clog2(HEADER_STORE_DEPTH + 1);
  localparam int IW = $clog2(HEADER_STORE_DEPTH);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HEAD1 = 2'd1;
  localparam logic [1:0] PH_HEAD2 = 2'd2;
  localparam logic [1:0] PH_PAY = 2'd3;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PROC = 3'd1;
  localparam logic [2:0] S_CRC  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_EMH  = 3'd4;
  localparam logic [2:0] S_EMP  = 3'd5;

  localparam logic [HW-1:0] HDepth = HW'(HEADER_STORE_DEPTH);

  logic [7:0]    store_r [HEADER_STORE_DEPTH];
  logic [7:0]    store_nxt [HEADER_STORE_DEPTH];
  logic [HW-1:0] held_r, held_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic          long_r, long_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic          ov_r, ov_nxt;
  logic [7:0]    ob_r, ob_nxt;
  logic          ol_r, ol_nxt;
  logic [2:0]    ou_r, ou_nxt;

  logic          out_free;
  logic [1:0]    ph_eff;
  logic [HW-1:0] hlen, h;
  logic [7:0]    lo, hi;
  logic [15:0]   held_crc;

  assign out_free = !ov_r || out_tready;
  assign lo       = sync_word[7:0];
  assign hi       = sync_word[15:8];
  assign hlen     = long_r ? HW'(scdd_pkg::LongHdrLen) : HW'(scdd_pkg::ShortHdrLen);
  assign held_crc = long_r ? {store_r[scdd_pkg::LongHdrLen-1], store_r[scdd_pkg::LongHdrLen-2]}
                           : {store_r[scdd_pkg::ShortHdrLen-1],
                              store_r[scdd_pkg::ShortHdrLen-2]};
  assign ph_eff   = (phase_r == PH_PAY && rem_r == 32'd0) ? PH_HUNT : phase_r;
  assign q_pop    = (st_r == S_IDLE) && out_free;

  always_comb begin
    for (int i = 0; i < HEADER_STORE_DEPTH; i++) begin
      store_nxt[i] = store_r[i];
    end
    held_nxt  = held_r;
    phase_nxt = phase_r;
    long_nxt  = long_r;
    rem_nxt   = rem_r;
    st_nxt    = st_r;
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    ov_nxt    = ov_r && !out_tready;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    ou_nxt    = ou_r;
    h         = held_r;

    case (st_r)
      S_IDLE: begin
        if (q_in.valid && out_free) begin
          if (ph_eff == PH_PAY && held_r == '0) begin
            rem_nxt = rem_r - 32'd1;
            ov_nxt  = 1'b1;
            ob_nxt  = q_in.data;
            ol_nxt  = (rem_r == 32'd1);
            ou_nxt  = {1'b0, 1'b0, scdd_pkg::KIND_DATA};
            if (rem_r == 32'd1) begin
              phase_nxt = PH_HUNT;
            end
          end else begin
            if (ph_eff == PH_PAY) begin
              h = '0;
              phase_nxt = PH_HUNT;
            end else begin
              phase_nxt = ph_eff;
            end
            if (h == HDepth) begin
              for (int i = 0; i < HEADER_STORE_DEPTH - 1; i++) begin
                store_nxt[i] = store_r[i+1];
              end
              store_nxt[HEADER_STORE_DEPTH-1] = q_in.data;
              held_nxt = HDepth;
            end else begin
              store_nxt[h[IW-1:0]] = q_in.data;
              held_nxt = h + HW'(1);
            end
            st_nxt = S_PROC;
          end
        end
      end
      S_PROC: begin
        case (phase_r)
          PH_HUNT: begin
            if (held_r < HW'(2)) begin
              st_nxt = S_IDLE;
            end else if (store_r[0] == lo && store_r[1] == hi) begin
              phase_nxt = PH_HEAD1;
            end else begin
              for (int i = 0; i < HEADER_STORE_DEPTH - 1; i++) begin
                store_nxt[i] = store_r[i+1];
              end
              held_nxt = held_r - HW'(1);
            end
          end
          PH_HEAD1: begin
            if (held_r < HW'(scdd_pkg::ShortHdrLen)) begin
              st_nxt = S_IDLE;
            end else begin
              long_nxt  = store_r[3][7];
              phase_nxt = PH_HEAD2;
            end
          end
          PH_HEAD2: begin
            if (held_r < hlen) begin
              st_nxt = S_IDLE;
            end else begin
              idx_nxt = '0;
              crc_nxt = 16'h0000;
              st_nxt  = S_CRC;
            end
          end
          default: begin
            st_nxt = S_IDLE;
          end
        endcase
      end
      S_CRC: begin
        crc_nxt = scdd_pkg::crc_byte(crc_r, store_r[idx_r]);
        idx_nxt = idx_r + IW'(1);
        if ({1'b0, idx_r} == hlen - HW'(3)) begin
          st_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (store_r[0] == lo && store_r[1] == hi && held_crc == crc_r) begin
          rem_nxt = {store_r[7], store_r[6], store_r[5], store_r[4]};
          idx_nxt = '0;
          st_nxt  = S_EMH;
        end else if (out_free) begin
          ov_nxt = 1'b1;
          ob_nxt = 8'h00;
          ol_nxt = 1'b0;
          ou_nxt = {1'b0, 1'b0, scdd_pkg::KIND_NOTICE};
          for (int i = 0; i < HEADER_STORE_DEPTH - 1; i++) begin
            store_nxt[i] = store_r[i+1];
          end
          held_nxt  = held_r - HW'(1);
          phase_nxt = PH_HUNT;
          st_nxt    = S_PROC;
        end
      end
      S_EMH: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          ob_nxt = store_r[0];
          ol_nxt = ({1'b0, idx_r} == hlen - HW'(1)) && rem_r == 32'd0;
          ou_nxt = {1'b1, idx_r == '0, scdd_pkg::KIND_DATA};
          for (int i = 0; i < HEADER_STORE_DEPTH - 1; i++) begin
            store_nxt[i] = store_r[i+1];
          end
          held_nxt = held_r - HW'(1);
          idx_nxt  = idx_r + IW'(1);
          if ({1'b0, idx_r} == hlen - HW'(1)) begin
            if (rem_r == 32'd0) begin
              phase_nxt = PH_HUNT;
              st_nxt    = S_IDLE;
            end else begin
              phase_nxt = PH_PAY;
              st_nxt    = S_EMP;
            end
          end
        end
      end
      S_EMP: begin
        if (held_r == '0 || rem_r == 32'd0) begin
          phase_nxt = (rem_r == 32'd0) ? PH_HUNT : PH_PAY;
          st_nxt    = S_IDLE;
        end else if (out_free) begin
          ov_nxt  = 1'b1;
          ob_nxt  = store_r[0];
          ol_nxt  = (rem_r == 32'd1);
          ou_nxt  = {1'b0, 1'b0, scdd_pkg::KIND_DATA};
          rem_nxt = rem_r - 32'd1;
          for (int i = 0; i < HEADER_STORE_DEPTH - 1; i++) begin
            store_nxt[i] = store_r[i+1];
          end
          held_nxt = held_r - HW'(1);
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      phase_r <= PH_HUNT;
      long_r  <= 1'b0;
      rem_r   <= 32'd0;
      st_r    <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      held_r  <= held_nxt;
      phase_r <= phase_nxt;
      long_r  <= long_nxt;
      rem_r   <= rem_nxt;
      st_r    <= st_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < HEADER_STORE_DEPTH; i++) begin
      store_r[i] <= store_nxt[i];
    end
    idx_r <= idx_nxt;
    crc_r <= crc_nxt;
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
    ou_r  <= ou_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = ob_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = ou_r;

endmodule

// File: src/sync_crc_datagram_deframer_top.sv
// Top level of the sync-word, CRC-checked datagram deframer.
// Payload bytes that arrive once the header has been emitted pass through at one per cycle while out_tready holds.
// Other bytes go through the shared back-end sequencer, which stores each byte, then runs hunt
// steps, CRC steps over the header and header emission; it pops no new byte until it is idle.
// Each result is registered before it appears on the output.
// Synchronous active-low reset clears the queue, the sequencer, the phase and sync_word.
module sync_crc_datagram_deframer_top #(
  parameter int HEADER_STORE_DEPTH = scdd_pkg::HdrStoreDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic        out_tlast,
  output logic [2:0]  out_tuser,   // [0] kind, [1] first_byte, [2] in_header
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  scdd_pkg::byte_q_t q;
  logic              q_pop;
  logic [15:0]       sync_word;

  scdd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .q_out      (q),
    .q_pop      (q_pop),
    .sync_word  (sync_word)
  );

  scdd_back #(
    .HEADER_STORE_DEPTH(HEADER_STORE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_in      (q),
    .q_pop     (q_pop),
    .sync_word (sync_word),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

// File: tb/tb.sv
// Testbench for the sync-word CRC datagram deframer, checked against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [0:0] kind;
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       hdr;
  } frame_byte_t;

  typedef enum logic [1:0] {SEEK, HOLD_FIXED, HOLD_FULL, BODY} seek_phase_t;

  class deframe_scoreboard;
    logic [15:0] sync;
    seek_phase_t phase;
    logic [7:0]  held[$];
    logic        long_hdr;
    logic [31:0] remaining;
    frame_byte_t pending[$];
    int          errors;

    function void clear();
      phase = SEEK;
      held.delete();
      long_hdr = 0;
      remaining = 0;
      pending.delete();
      errors = 0;
      sync = 16'h0000;
    endfunction

    function void emit(logic [0:0] k, logic [7:0] d, logic f, logic l, logic h);
      frame_byte_t e;
      e.kind = k;
      e.data = d;
      e.first = f;
      e.last = l;
      e.hdr = h;
      pending.push_back(e);
    endfunction

    function logic [15:0] calc_crc(int len);
      logic [15:0] c;
      c = 16'h0000;
      for (int i = 0; i < len; i++) begin
        c = c ^ {8'h00, held[i]};
        for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
    endfunction

    function void scan();
      int pos;
      int hlen;
      logic [15:0] got;
      forever begin
        if (phase == SEEK) begin
          if (held.size() < 2) return;
          pos = -1;
          for (int i = 0; i + 1 < held.size(); i++) begin
            if (held[i] == sync[7:0] && held[i+1] == sync[15:8]) begin
              pos = i;
              break;
            end
          end
          if (pos < 0) begin
            held = held[held.size()-1:held.size()-1];
            return;
          end
          repeat (pos) void'(held.pop_front());
          phase = HOLD_FIXED;
        end
        if (phase == HOLD_FIXED) begin
          if (held.size() < scdd_pkg::ShortHdrLen) return;
          long_hdr = held[3][7];
          phase = HOLD_FULL;
        end
        if (phase == HOLD_FULL) begin
          hlen = long_hdr ? scdd_pkg::LongHdrLen : scdd_pkg::ShortHdrLen;
          if (held.size() < hlen) return;
          got = {held[hlen-1], held[hlen-2]};
          if (held[0] == sync[7:0] && held[1] == sync[15:8] && got == calc_crc(hlen - 2)) begin
            remaining = {held[7], held[6], held[5], held[4]};
            for (int i = 0; i < hlen; i++)
              emit(scdd_pkg::KIND_DATA, held[i], i == 0, i == hlen - 1 && remaining == 0,
                   1'b1);
            repeat (hlen) void'(held.pop_front());
            if (remaining == 0) begin
              phase = SEEK;
              return;
            end
            phase = BODY;
            while (held.size() > 0 && remaining != 0) begin
              remaining--;
              emit(scdd_pkg::KIND_DATA, held.pop_front(), 1'b0, remaining == 0, 1'b0);
            end
            if (remaining == 0) phase = SEEK;
            return;
          end
          emit(scdd_pkg::KIND_NOTICE, 8'h00, 1'b0, 1'b0, 1'b0);
          void'(held.pop_front());
          phase = SEEK;
          continue;
        end
        return;
      end
    endfunction

    function void note_input(logic [7:0] b);
      if (phase == BODY && remaining == 0) phase = SEEK;
      if (phase == BODY && held.size() == 0) begin
        remaining--;
        emit(scdd_pkg::KIND_DATA, b, 1'b0, remaining == 0, 1'b0);
        if (remaining == 0) phase = SEEK;
        return;
      end
      if (phase == BODY) begin
        held.delete();
        phase = SEEK;
      end
      if (held.size() >= scdd_pkg::HdrStoreDepth) void'(held.pop_front());
      held.push_back(b);
      scan();
    endfunction

    function void check_result(frame_byte_t got);
      frame_byte_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result k=%0d d=%h", got.kind, got.data);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp k%0d d%h f%0d l%0d h%0d got k%0d d%h f%0d l%0d h%0d",
                   exp.kind, exp.data, exp.first, exp.last, exp.hdr,
                   got.kind, got.data, got.first, got.last, got.hdr);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [7:0] in_tdata = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [7:0] out_tdata;
  logic out_tlast;
  logic [2:0] out_tuser;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0] cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  deframe_scoreboard sb = new();
  bit calm;
  int cycles = 0;
  logic [7:0] stim[$];

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  sync_crc_datagram_deframer_top u_top (.*);

  always @(posedge clk) begin
    frame_byte_t r;
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: FAIL");
      $finish;
    end
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata);
      if (out_tvalid && out_tready) begin
        r.kind = out_tuser[0];
        r.data = out_tdata;
        r.first = out_tuser[1];
        r.last = out_tlast;
        r.hdr = out_tuser[2];
        sb.check_result(r);
      end
      out_tready <= calm || ($urandom_range(99) >= 16);
    end
  end

  task automatic write_sync(logic [15:0] v);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= scdd_pkg::CFG_ADDR_SYNC;
    cfg_pwdata <= {16'h0, v};
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    sb.sync = v;
    @(posedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    while (!calm && $urandom_range(99) < 16) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Builds a frame with a valid or corrupted CRC and a payload of plen random bytes.
  task automatic queue_frame(bit long_hdr, int plen, bit corrupt);
    logic [7:0] h[16];
    logic [15:0] c;
    int hlen;
    hlen = long_hdr ? 16 : 12;
    h[0] = sb.sync[7:0];
    h[1] = sb.sync[15:8];
    h[2] = 8'($urandom);
    h[3] = {long_hdr, 7'($urandom)};
    {h[7], h[6], h[5], h[4]} = plen;
    for (int i = 8; i < 16; i++) h[i] = 8'($urandom);
    c = 16'h0000;
    for (int i = 0; i < hlen - 2; i++) begin
      c = c ^ {8'h00, h[i]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    if (corrupt) c = c ^ (16'h1 << $urandom_range(15));
    h[hlen-2] = c[7:0];
    h[hlen-1] = c[15:8];
    for (int i = 0; i < hlen; i++) stim.push_back(h[i]);
    for (int i = 0; i < plen; i++) stim.push_back(8'($urandom));
  endtask

  task automatic play();
    while (stim.size() > 0) send_byte(stim.pop_front());
    in_tvalid <= 0;
  endtask

  initial begin
    logic [15:0] syncs[4];
    int n;
    sb.clear();
    calm = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    write_sync(16'h0000);
    // The directed part covers a zero payload, a long header, a bad CRC and noise bytes.
    write_sync(16'hB55A);
    queue_frame(0, 0, 0);
    queue_frame(1, 2, 0);
    stim.push_back(8'hFF);
    stim.push_back(8'h00);
    queue_frame(0, 1, 1);
    play();
    drain();
    // The sync word changes while a header is partly held.
    stim.push_back(8'h5A);
    stim.push_back(8'hB5);
    for (int i = 0; i < 4; i++) stim.push_back(8'($urandom));
    play();
    drain();
    write_sync(16'hFFFF);
    for (int i = 0; i < 8; i++) stim.push_back(8'($urandom));
    play();
    drain();
    syncs = '{16'h0000, 16'hFFFF, 16'hB55A, 16'h1234};
    n = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_sync(ph == 3 ? 16'($urandom) : syncs[ph]);
      calm = (ph == 2);
      while (n < 30) begin
        case ($urandom_range(9))
          0: repeat ($urandom_range(1, 4)) stim.push_back(8'($urandom));
          1: queue_frame($urandom_range(1), $urandom_range(3), 1);
          default: queue_frame($urandom_range(1), $urandom_range(5), 0);
        endcase
        n += stim.size();
        play();
      end
      n = 0;
      drain();
    end
    calm = 0;
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
